// ===== rtl/bmhq_pkg.sv =====
// Shared types, codes and the microcode program of the binary max-heap queue.
// Depends on nothing; used by binary_max_heap_queue, bmhq_checker and the testbench.
`default_nettype none

package bmhq_pkg;

  localparam int CAPACITY_DEF = 128;
  localparam int KEY_W        = 32;
  localparam int OP_W         = 3;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 8;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_LOAD   = 3'd3,
    OP_BUILD  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Microcode addresses.
  typedef enum logic [3:0] {
    S_DONE     = 4'd0,
    S_FETCH    = 4'd1,
    S_ADD      = 4'd2,
    S_ADD_WAY  = 4'd3,
    S_UP_RD    = 4'd4,
    S_UP_MV    = 4'd5,
    S_RM_RD    = 4'd6,
    S_RM_TAKE  = 4'd7,
    S_DN_RD    = 4'd8,
    S_DN_MV    = 4'd9,
    S_WR_KEY   = 4'd10,
    S_CLR      = 4'd11,
    S_B_INIT   = 4'd12,
    S_B_RD     = 4'd13,
    S_B_KEY    = 4'd14,
    S_B_DEC    = 4'd15
  } step_t;

  typedef enum logic [3:0] {
    A_EMIT,
    A_LATCH,
    A_ADD,
    A_NONE,
    A_RD_PARENT,
    A_UP_MOVE,
    A_RD_ENDS,
    A_RM_TAKE,
    A_RD_KIDS,
    A_DN_MOVE,
    A_WR_KEY,
    A_CLEAR,
    A_B_INIT,
    A_B_RD,
    A_B_KEY,
    A_B_DEC
  } act_t;

  typedef enum logic [3:0] {
    C_TRUE,
    C_OUT_BUSY,
    C_FULL,
    C_IS_LOAD,
    C_AT_ROOT,
    C_UP_STOP,
    C_EMPTY,
    C_LEAF,
    C_DN_STOP,
    C_BUILD_MODE,
    C_BI_ZERO
  } cond_t;

  typedef enum logic {
    SQ_BRANCH,
    SQ_DISPATCH
  } seq_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    seq_t  seq;
    step_t jump_to;
    step_t fall_to;
  } ucode_t;

  // The control store: one word per step.
  function automatic ucode_t ucode(input step_t s);
    ucode_t w;
    case (s)
      S_DONE:    w = '{A_EMIT,      C_OUT_BUSY,   SQ_BRANCH,   S_DONE,   S_FETCH};
      S_FETCH:   w = '{A_LATCH,     C_TRUE,       SQ_DISPATCH, S_FETCH,  S_FETCH};
      S_ADD:     w = '{A_ADD,       C_FULL,       SQ_BRANCH,   S_DONE,   S_ADD_WAY};
      S_ADD_WAY: w = '{A_NONE,      C_IS_LOAD,    SQ_BRANCH,   S_WR_KEY, S_UP_RD};
      S_UP_RD:   w = '{A_RD_PARENT, C_AT_ROOT,    SQ_BRANCH,   S_WR_KEY, S_UP_MV};
      S_UP_MV:   w = '{A_UP_MOVE,   C_UP_STOP,    SQ_BRANCH,   S_WR_KEY, S_UP_RD};
      S_RM_RD:   w = '{A_RD_ENDS,   C_EMPTY,      SQ_BRANCH,   S_DONE,   S_RM_TAKE};
      S_RM_TAKE: w = '{A_RM_TAKE,   C_TRUE,       SQ_BRANCH,   S_DN_RD,  S_DN_RD};
      S_DN_RD:   w = '{A_RD_KIDS,   C_LEAF,       SQ_BRANCH,   S_WR_KEY, S_DN_MV};
      S_DN_MV:   w = '{A_DN_MOVE,   C_DN_STOP,    SQ_BRANCH,   S_WR_KEY, S_DN_RD};
      S_WR_KEY:  w = '{A_WR_KEY,    C_BUILD_MODE, SQ_BRANCH,   S_B_DEC,  S_DONE};
      S_CLR:     w = '{A_CLEAR,     C_TRUE,       SQ_BRANCH,   S_DONE,   S_DONE};
      S_B_INIT:  w = '{A_B_INIT,    C_TRUE,       SQ_BRANCH,   S_B_RD,   S_B_RD};
      S_B_RD:    w = '{A_B_RD,      C_BI_ZERO,    SQ_BRANCH,   S_DONE,   S_B_KEY};
      S_B_KEY:   w = '{A_B_KEY,     C_TRUE,       SQ_BRANCH,   S_DN_RD,  S_DN_RD};
      S_B_DEC:   w = '{A_B_DEC,     C_TRUE,       SQ_BRANCH,   S_B_RD,   S_B_RD};
      default:   w = '{A_NONE,      C_TRUE,       SQ_BRANCH,   S_FETCH,  S_FETCH};
    endcase
    return w;
  endfunction

  // Entry point of each operation's routine.
  function automatic step_t dispatch(input logic [OP_W-1:0] op);
    step_t s;
    case (op)
      OP_INSERT, OP_LOAD: s = S_ADD;
      OP_REMOVE:          s = S_RM_RD;
      OP_CLEAR:           s = S_CLR;
      OP_BUILD:           s = S_B_INIT;
      default:            s = S_DONE;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_max_heap_queue.sv =====
// Top level of the binary max-heap queue: microcoded sequencer, key memory and
// output register. Depends on bmhq_pkg for codes, types and the control store.
//
// Usage: each word on the in_ channel is one operation (in_tuser) with a key
// (in_tdata) for insert and load. Each operation yields exactly one word on the
// out_ channel: status in out_tuser, the removed maximum and the entry count in
// out_tdata. Operations are handled one at a time; in_tready is high only while
// the sequencer waits for the next word.
// Steps: an unused code goes straight to the result step; clear passes its
// clear step; overflow and underflow stop after the add or read step; load
// writes the key in place; insert adds it, rises level by level and writes the
// key; remove reads the root and the last slot, takes the maximum and sinks
// the last key. Build sinks each internal node in turn, last to root. A sift
// level reads the memory, whose read data is registered, then compares and
// writes back a moved key.
// The result sits in an output register; the next word can be accepted in the
// first cycle out_tvalid is high. If the receiver stalls, the sequencer holds
// at its final step until the register frees. Reset empties the queue, drops
// out_tvalid and leaves in_tready high; the key memory is not cleared and
// needs no clearing pass.
`default_nettype none

module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [bmhq_pkg::IN_DATA_W-1:0]   in_tdata,   // [31:0] key_in
  input  wire logic [bmhq_pkg::OP_W-1:0]        in_tuser,   // [2:0] operation
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [bmhq_pkg::OUT_DATA_W-1:0]       out_tdata,  // [31:0] key_out,
                                                            // [39:32] entry_count
  output logic [bmhq_pkg::STATUS_W-1:0]         out_tuser   // [1:0] status
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int AW    = $clog2(CAPACITY + 2);
  localparam int DEPTH = CAPACITY + 2;
  localparam int KW    = bmhq_pkg::KEY_W;

  // Slots 1..count hold keys; slot 0 and the top slot are never written.
  logic signed [KW-1:0] mem [DEPTH];

  bmhq_pkg::step_t   upc_r, upc_nxt;
  bmhq_pkg::ucode_t  uw;
  logic              cond_val;
  logic              in_acc;
  logic              out_busy;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 build_mode_r, build_mode_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [AW-1:0]        bi_r, bi_nxt;
  logic signed [KW-1:0] k_r, k_nxt;
  logic signed [KW-1:0] key_r, key_nxt;
  logic [bmhq_pkg::OP_W-1:0] op_r, op_nxt;
  logic signed [KW-1:0] rd_a_r, rd_b_r;
  bmhq_pkg::status_t    status_r, status_nxt;
  logic signed [KW-1:0] keyout_r, keyout_nxt;

  logic                    out_valid_r, out_valid_nxt;
  bmhq_pkg::status_t       out_status_r, out_status_nxt;
  logic signed [KW-1:0]    out_key_r, out_key_nxt;
  logic [bmhq_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr_a, rd_addr_b;
  logic signed [KW-1:0] wr_data;

  logic [AW-1:0]        kid_l, kid_r;
  logic                 leaf, use_right, up_stop, dn_stop;
  logic signed [KW-1:0] kid_val;
  logic [AW-1:0]        kid_pos;

  assign uw        = bmhq_pkg::ucode(upc_r);
  assign in_tready = (upc_r == bmhq_pkg::S_FETCH);
  assign in_acc    = in_tvalid && in_tready;
  assign out_busy  = out_valid_r && !out_tready;

  assign kid_l     = AW'({pos_r, 1'b0});
  assign kid_r     = kid_l + AW'(1);
  assign leaf      = pos_r > AW'(cnt_r >> 1);
  assign use_right = (kid_l < AW'(cnt_r)) && (rd_a_r < rd_b_r);
  assign kid_val   = use_right ? rd_b_r : rd_a_r;
  assign kid_pos   = use_right ? kid_r : kid_l;
  assign up_stop   = !(rd_a_r < k_r);
  assign dn_stop   = !(k_r < kid_val);

  // Condition select and next microcode address.
  always_comb begin
    case (uw.cond)
      bmhq_pkg::C_TRUE:       cond_val = 1'b1;
      bmhq_pkg::C_OUT_BUSY:   cond_val = out_busy;
      bmhq_pkg::C_FULL:       cond_val = (cnt_r == CW'(CAPACITY));
      bmhq_pkg::C_IS_LOAD:    cond_val = (op_r == bmhq_pkg::OP_LOAD);
      bmhq_pkg::C_AT_ROOT:    cond_val = (pos_r == AW'(1));
      bmhq_pkg::C_UP_STOP:    cond_val = up_stop;
      bmhq_pkg::C_EMPTY:      cond_val = (cnt_r == '0);
      bmhq_pkg::C_LEAF:       cond_val = leaf;
      bmhq_pkg::C_DN_STOP:    cond_val = dn_stop;
      bmhq_pkg::C_BUILD_MODE: cond_val = build_mode_r;
      bmhq_pkg::C_BI_ZERO:    cond_val = (bi_r == '0);
      default:                cond_val = 1'b1;
    endcase
    case (uw.seq)
      bmhq_pkg::SQ_DISPATCH:
        upc_nxt = in_acc ? bmhq_pkg::dispatch(in_tuser) : bmhq_pkg::S_FETCH;
      default:
        upc_nxt = cond_val ? uw.jump_to : uw.fall_to;
    endcase
  end

  // Datapath controlled by the current control word.
  always_comb begin
    cnt_nxt        = cnt_r;
    build_mode_nxt = build_mode_r;
    pos_nxt        = pos_r;
    bi_nxt         = bi_r;
    k_nxt          = k_r;
    key_nxt        = key_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    keyout_nxt     = keyout_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_cnt_nxt    = out_cnt_r;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = k_r;
    rd_en          = 1'b0;
    rd_addr_a      = pos_r;
    rd_addr_b      = pos_r;

    case (uw.act)
      bmhq_pkg::A_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_key_nxt    = keyout_r;
          out_cnt_nxt    = bmhq_pkg::COUNT_W'(cnt_r);
        end
      end
      bmhq_pkg::A_LATCH: begin
        if (in_acc) begin
          op_nxt         = in_tuser;
          key_nxt        = in_tdata;
          status_nxt     = bmhq_pkg::ST_OK;
          keyout_nxt     = '0;
          build_mode_nxt = 1'b0;
        end
      end
      bmhq_pkg::A_ADD: begin
        if (cnt_r == CW'(CAPACITY)) begin
          status_nxt = bmhq_pkg::ST_OVERFLOW;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
          pos_nxt = AW'(cnt_r) + AW'(1);
          k_nxt   = key_r;
        end
      end
      bmhq_pkg::A_RD_PARENT: begin
        rd_en     = 1'b1;
        rd_addr_a = pos_r >> 1;
        rd_addr_b = pos_r >> 1;
      end
      bmhq_pkg::A_UP_MOVE: begin
        // Parent smaller than the rising key: it drops into the hole.
        if (!up_stop) begin
          wr_en   = 1'b1;
          wr_data = rd_a_r;
          pos_nxt = pos_r >> 1;
        end
      end
      bmhq_pkg::A_RD_ENDS: begin
        rd_en     = 1'b1;
        rd_addr_a = AW'(1);
        rd_addr_b = AW'(cnt_r);
        if (cnt_r == '0) begin
          status_nxt = bmhq_pkg::ST_UNDERFLOW;
        end
      end
      bmhq_pkg::A_RM_TAKE: begin
        keyout_nxt = rd_a_r;
        k_nxt      = rd_b_r;
        cnt_nxt    = cnt_r - CW'(1);
        pos_nxt    = AW'(1);
      end
      bmhq_pkg::A_RD_KIDS: begin
        // Both children fit in the memory whenever the node is internal.
        rd_en     = !leaf;
        rd_addr_a = kid_l;
        rd_addr_b = kid_r;
      end
      bmhq_pkg::A_DN_MOVE: begin
        if (!dn_stop) begin
          wr_en   = 1'b1;
          wr_data = kid_val;
          pos_nxt = kid_pos;
        end
      end
      bmhq_pkg::A_WR_KEY: begin
        wr_en = 1'b1;
      end
      bmhq_pkg::A_CLEAR: begin
        cnt_nxt = '0;
      end
      bmhq_pkg::A_B_INIT: begin
        bi_nxt         = AW'(cnt_r >> 1);
        build_mode_nxt = 1'b1;
      end
      bmhq_pkg::A_B_RD: begin
        pos_nxt   = bi_r;
        rd_en     = 1'b1;
        rd_addr_a = bi_r;
        rd_addr_b = bi_r;
      end
      bmhq_pkg::A_B_KEY: begin
        k_nxt = rd_a_r;
      end
      bmhq_pkg::A_B_DEC: begin
        bi_nxt = bi_r - AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r        <= bmhq_pkg::S_FETCH;
      cnt_r        <= '0;
      build_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      upc_r        <= upc_nxt;
      cnt_r        <= cnt_nxt;
      build_mode_r <= build_mode_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    bi_r         <= bi_nxt;
    k_r          <= k_nxt;
    key_r        <= key_nxt;
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    keyout_r     <= keyout_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_key_r};
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

// ===== rtl/bmhq_checker.sv =====
// Port-level checks for the binary max-heap queue, bound to its top level.
// Depends on bmhq_pkg for widths and status codes.
`default_nettype none

module bmhq_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [bmhq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire logic [bmhq_pkg::STATUS_W-1:0]    out_tuser
);

  // Reset leaves no result pending.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // One operation at a time: the sequencer leaves its wait step on acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  // An underflow only happens on an empty queue and returns no key.
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == bmhq_pkg::ST_UNDERFLOW |->
      out_tdata == '0)
    else $error("underflow with key or nonzero count");

  // Overflow returns no key; status code three never appears.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == bmhq_pkg::ST_OK) ||
      (out_tuser == bmhq_pkg::ST_UNDERFLOW) ||
      ((out_tuser == bmhq_pkg::ST_OVERFLOW) && (out_tdata[31:0] == '0)))
    else $error("bad status or key on overflow");

endmodule

bind binary_max_heap_queue bmhq_checker u_bmhq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ===== sim/binary_max_heap_queue_test.sv =====
// Self-checking testbench for the binary max-heap queue: drives operations on the
// in_ stream, predicts every result with its own heap model and checks the out_ stream.
// Depends on bmhq_pkg and binary_max_heap_queue.
`timescale 1ns / 1ps

module binary_max_heap_queue_test;

  localparam int HEAP_CAP = bmhq_pkg::CAPACITY_DEF;
  localparam logic [bmhq_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [bmhq_pkg::OP_W-1:0] OP_SPARE_LAST = 3'd7;
  localparam logic [bmhq_pkg::KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic [bmhq_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 100;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    bmhq_pkg::status_t status;
    logic [bmhq_pkg::KEY_W-1:0] key;
    logic [bmhq_pkg::COUNT_W-1:0] count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [bmhq_pkg::IN_DATA_W-1:0] in_tdata = '0;   // [31:0] key_in
  logic [bmhq_pkg::OP_W-1:0] in_tuser = '0;        // [2:0] operation
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [bmhq_pkg::OUT_DATA_W-1:0] out_tdata;      // [31:0] key_out, [39:32] entry_count
  logic [bmhq_pkg::STATUS_W-1:0] out_tuser;        // [1:0] status

  // Model of the heap, slots 1..heap_fill hold keys.
  logic signed [bmhq_pkg::KEY_W-1:0] heap_keys [1:HEAP_CAP];
  int unsigned heap_fill = 0;

  heap_result_t pending_results [$];
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int overflow_seen = 0;
  int underflow_seen = 0;
  int peak_count_seen = 0;
  int cycle_count = 0;
  bit idle_enable = 1'b1;
  bit hold_request = 1'b0;

  binary_max_heap_queue #(.CAPACITY(HEAP_CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void swap_keys(input int unsigned a, input int unsigned b);
    logic signed [bmhq_pkg::KEY_W-1:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void sift_down_from(input int unsigned pos, input int unsigned n);
    int unsigned kid;
    while (pos >= 1 && pos <= n / 2) begin
      kid = 2 * pos;
      // The right child wins only when strictly larger than the left one.
      if (kid < n && heap_keys[kid] < heap_keys[kid + 1]) kid = kid + 1;
      if (!(heap_keys[pos] < heap_keys[kid])) break;
      swap_keys(pos, kid);
      pos = kid;
    end
  endfunction

  function automatic heap_result_t predict_heap_op(input logic [bmhq_pkg::OP_W-1:0] op,
                                                   input logic [bmhq_pkg::KEY_W-1:0] key);
    heap_result_t res;
    int unsigned pos;
    res.status = bmhq_pkg::ST_OK;
    res.key = '0;
    case (op)
      bmhq_pkg::OP_INSERT, bmhq_pkg::OP_LOAD: begin
        if (heap_fill >= HEAP_CAP) begin
          res.status = bmhq_pkg::ST_OVERFLOW;
        end else begin
          heap_fill = heap_fill + 1;
          heap_keys[heap_fill] = key;
          if (op == bmhq_pkg::OP_INSERT) begin
            pos = heap_fill;
            while (pos > 1 && heap_keys[pos / 2] < heap_keys[pos]) begin
              swap_keys(pos / 2, pos);
              pos = pos / 2;
            end
          end
        end
      end
      bmhq_pkg::OP_REMOVE: begin
        if (heap_fill == 0) begin
          res.status = bmhq_pkg::ST_UNDERFLOW;
        end else begin
          res.key = heap_keys[1];
          heap_keys[1] = heap_keys[heap_fill];
          heap_fill = heap_fill - 1;
          sift_down_from(1, heap_fill);
        end
      end
      bmhq_pkg::OP_CLEAR: heap_fill = 0;
      bmhq_pkg::OP_BUILD: begin
        for (pos = heap_fill / 2; pos > 0; pos--) sift_down_from(pos, heap_fill);
      end
      default: ;
    endcase
    res.count = heap_fill[bmhq_pkg::COUNT_W-1:0];
    return res;
  endfunction

  // Mostly full-range keys, with extremes and a narrow band that makes ties.
  function automatic logic [bmhq_pkg::KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom();
    if (r == 7) return $urandom_range(0, 8) - 4;
    if (r == 8) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom_range(0, 1) ? KEY_MAX - $urandom_range(0, 3)
                                : KEY_MIN + $urandom_range(0, 3);
  endfunction

  // Sends one word; the expected result is computed at the accepting edge.
  task automatic push_op(input logic [bmhq_pkg::OP_W-1:0] op,
                         input logic [bmhq_pkg::KEY_W-1:0] key);
    int gap;
    gap = (idle_enable && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= key;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_heap_op(op, key));
    sent_count++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_queue();
    push_op(bmhq_pkg::OP_REMOVE, pick_key());
    push_op(bmhq_pkg::OP_BUILD, pick_key());
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
      push_op(bmhq_pkg::OP_W'(c), $urandom());
    push_op(bmhq_pkg::OP_LOAD, KEY_MIN);
    push_op(bmhq_pkg::OP_BUILD, '0);
  endtask

  task automatic test_key_extremes();
    push_op(bmhq_pkg::OP_INSERT, KEY_MAX);
    push_op(bmhq_pkg::OP_INSERT, '0);
    push_op(bmhq_pkg::OP_INSERT, '1);
    push_op(bmhq_pkg::OP_INSERT, KEY_MAX);
    push_op(bmhq_pkg::OP_REMOVE, '1);
  endtask

  task automatic test_unordered_build();
    push_op(bmhq_pkg::OP_LOAD, 32'd1);
    push_op(bmhq_pkg::OP_LOAD, 32'h4000_0000);
    push_op(bmhq_pkg::OP_BUILD, '0);
    push_op(bmhq_pkg::OP_REMOVE, '0);
    push_op(bmhq_pkg::OP_REMOVE, '0);
    push_op(bmhq_pkg::OP_INSERT, KEY_MIN);
  endtask

  task automatic test_clear();
    push_op(bmhq_pkg::OP_CLEAR, $urandom());
    push_op(bmhq_pkg::OP_REMOVE, '0);
    push_op(bmhq_pkg::OP_CLEAR, $urandom());
  endtask

  // Fills the store to the last slot, overflows it, builds it at full size
  // and drains it in order down to an underflow.
  task automatic test_capacity();
    push_op(bmhq_pkg::OP_CLEAR, '0);
    repeat (HEAP_CAP) push_op(bmhq_pkg::OP_LOAD, pick_key());
    push_op(bmhq_pkg::OP_INSERT, pick_key());
    push_op(bmhq_pkg::OP_LOAD, pick_key());
    push_op(bmhq_pkg::OP_BUILD, '0);
    repeat (HEAP_CAP) push_op(bmhq_pkg::OP_REMOVE, pick_key());
    push_op(bmhq_pkg::OP_REMOVE, pick_key());
  endtask

  // The receiver stops for a long stretch while words keep coming.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (40)
      push_op($urandom_range(0, 1) ? bmhq_pkg::OP_INSERT : bmhq_pkg::OP_REMOVE, pick_key());
  endtask

  task automatic test_random_mix(input int n_ops, input int grow_pct, input bit allow_clear);
    int unsigned r;
    logic [bmhq_pkg::OP_W-1:0] op;
    repeat (n_ops) begin
      r = $urandom_range(0, 199);
      if (r < 6) op = bmhq_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      else if (r < 8) op = allow_clear ? bmhq_pkg::OP_CLEAR : bmhq_pkg::OP_REMOVE;
      else if (r < 18) op = bmhq_pkg::OP_BUILD;
      else if (r < 18 + 2 * grow_pct)
        op = ($urandom_range(0, 9) < 3) ? bmhq_pkg::OP_LOAD : bmhq_pkg::OP_INSERT;
      else op = bmhq_pkg::OP_REMOVE;
      push_op(op, pick_key());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    test_empty_queue();
    test_key_extremes();
    test_unordered_build();
    test_clear();
    test_capacity();
    test_output_backpressure();
    test_random_mix(600, 48, 1'b0);
    test_random_mix(400, 36, 1'b1);
    drain_results();
    idle_enable = 1'b0;
    test_random_mix(230, 43, 1'b1);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d operations and checked %0d results: peak count %0d,",
             sent_count, checked_count, peak_count_seen);
    $display("  %0d overflows and %0d underflows, with stalls on both streams.",
             overflow_seen, underflow_seen);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Ready generator: random stall bursts, or one long hold when requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    heap_result_t want;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("word with no operation outstanding: status %0d key_out %0d entry_count %0d",
               out_tuser, $signed(out_tdata[bmhq_pkg::KEY_W-1:0]),
               out_tdata[bmhq_pkg::OUT_DATA_W-1:bmhq_pkg::KEY_W]);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        checked_count++;
        if (want.status == bmhq_pkg::ST_OVERFLOW) overflow_seen++;
        if (want.status == bmhq_pkg::ST_UNDERFLOW) underflow_seen++;
        if (want.count > peak_count_seen) peak_count_seen = want.count;
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tuser);
          error_count++;
        end
        if (out_tdata[bmhq_pkg::KEY_W-1:0] !== want.key) begin
          $error("key_out: expected %0d, got %0d",
                 $signed(want.key), $signed(out_tdata[bmhq_pkg::KEY_W-1:0]));
          error_count++;
        end
        if (out_tdata[bmhq_pkg::OUT_DATA_W-1:bmhq_pkg::KEY_W] !== want.count) begin
          $error("entry_count: expected %0d, got %0d",
                 want.count, out_tdata[bmhq_pkg::OUT_DATA_W-1:bmhq_pkg::KEY_W]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== binary_max_heap_queue.f =====
rtl/bmhq_pkg.sv
rtl/binary_max_heap_queue.sv
rtl/bmhq_checker.sv
sim/binary_max_heap_queue_test.sv
